// File: rtl/threshold_interval_pixel_sort_macros.svh
// Assertion macros shared by the pixel sort RTL.
`ifndef THRESHOLD_INTERVAL_PIXEL_SORT_MACROS_SVH
`define THRESHOLD_INTERVAL_PIXEL_SORT_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define TIPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define TIPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tips_pkg.sv
// Types and constants of the threshold interval pixel sort.
package tips_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
	localparam int KEY_W     = 18;
	localparam int DIV_STEPS = 17;
	localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic CFG_SORT_KEY_MODE  = 1'b0;
	localparam logic CFG_LUMA_THRESHOLD = 1'b1;

	localparam logic [2:0] KEY_LUMA  = 3'd0;
	localparam logic [2:0] KEY_HUE   = 3'd1;
	localparam logic [2:0] KEY_SAT   = 3'd2;
	localparam logic [2:0] KEY_RED   = 3'd3;
	localparam logic [2:0] KEY_GREEN = 3'd4;
	localparam logic [2:0] KEY_BLUE  = 3'd5;

	typedef struct packed {
		logic       command;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
		logic       end_of_line_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       end_of_line_out;
		logic       nothing_ready;
	} out_word_t;

	// pixel packs {alpha, blue, green, red}
	typedef struct packed {
		logic [31:0]      pixel;
		logic [KEY_W-1:0] key;
		logic             run;
		logic             valid;
	} cell_t;

	typedef struct packed {
		logic shift;
		logic cmp;
		logic parity;
	} cell_ctl_t;

	typedef struct packed {
		logic             done;
		logic             run;
		logic [KEY_W-1:0] key;
	} key_res_t;

endpackage

// File: rtl/tips_cell.sv
// One sorting cell: shift from the lower neighbor or compare-swap with a neighbor.
module tips_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tips_pkg::cell_ctl_t ctl,
	input  logic                pos_odd,
	input  tips_pkg::cell_t     below,
	input  tips_pkg::cell_t     above,
	output tips_pkg::cell_t     cur
);

	tips_pkg::cell_t cell_q;
	tips_pkg::cell_t cell_d;
	logic            lower;
	logic            swap;

	always_comb begin
		lower = (pos_odd == ctl.parity);
		if (lower) begin
			swap = above.run && cell_q.run && (above.key > cell_q.key);
		end else begin
			swap = cell_q.run && below.run && (cell_q.key > below.key);
		end
		cell_d = cell_q;
		if (ctl.shift) begin
			cell_d = below;
		end else if (ctl.cmp && swap) begin
			cell_d = lower ? above : below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= cell_d;
		end
	end

	assign cur = cell_q;

endmodule

// File: rtl/tips_key.sv
// Sort key and run flag of one pixel, with a bit-serial divider for hue and saturation.
module tips_key (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         pixel,
	input  logic                valid,
	input  logic [2:0]          mode,
	input  logic [7:0]          thresh,
	output tips_pkg::key_res_t  res
);

	logic [7:0]                    r, g, b, mx, mn, d;
	logic [17:0]                   luma, lo_b, hi_b;
	logic [10:0]                   d6, hue_n, numer, dvs;
	logic                          run_c, need_div;
	logic [tips_pkg::KEY_W-1:0]    key_c;
	logic [11:0]                   rem_q, trial, rem_n;
	logic [10:0]                   dvs_q;
	logic [15:0]                   quo_q;
	logic [16:0]                   quo_n;
	logic [tips_pkg::DSTEP_W-1:0]  step_q;
	logic                          busy_q, done_q, run_q, ge;
	logic [tips_pkg::KEY_W-1:0]    key_q;

	always_comb begin
		r = pixel[7:0];
		g = pixel[15:8];
		b = pixel[23:16];
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		luma = 18'(r) * 18'd299 + 18'(g) * 18'd587 + 18'(b) * 18'd114;
		lo_b = 18'(thresh) * 18'd1000;
		hi_b = 18'd255000 - 18'(thresh) * 18'd500;
		run_c = valid && (luma > lo_b) && (luma < hi_b);
		d6 = 11'(d) * 11'd6;
		if (mx == r) begin
			hue_n = (g >= b) ? 11'(g - b) : d6 - 11'(b - g);
		end else if (mx == g) begin
			hue_n = 11'({d, 1'b0}) + 11'(b) - 11'(r);
		end else begin
			hue_n = 11'({d, 2'b00}) + 11'(r) - 11'(g);
		end
		need_div = 1'b0;
		numer = '0;
		dvs = '0;
		key_c = '0;
		unique case (mode)
			tips_pkg::KEY_HUE: begin
				need_div = (d != 8'd0);
				numer = hue_n;
				dvs = d6;
			end
			tips_pkg::KEY_SAT: begin
				need_div = (mx != 8'd0);
				numer = 11'(d);
				dvs = 11'(mx);
			end
			tips_pkg::KEY_RED:   key_c = tips_pkg::KEY_W'(r);
			tips_pkg::KEY_GREEN: key_c = tips_pkg::KEY_W'(g);
			tips_pkg::KEY_BLUE:  key_c = tips_pkg::KEY_W'(b);
			default:             key_c = luma;
		endcase
	end

	always_comb begin
		trial = (step_q == tips_pkg::DSTEP_W'(tips_pkg::DIV_STEPS)) ?
			rem_q : {rem_q[10:0], 1'b0};
		ge = (trial >= {1'b0, dvs_q});
		rem_n = ge ? trial - {1'b0, dvs_q} : trial;
		quo_n = {quo_q, ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			run_q  <= 1'b0;
			key_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= run_c;
				key_q  <= key_c;
				rem_q  <= {1'b0, numer};
				dvs_q  <= dvs;
				quo_q  <= '0;
				step_q <= tips_pkg::DSTEP_W'(tips_pkg::DIV_STEPS);
				busy_q <= need_div;
				done_q <= !need_div;
			end else if (busy_q) begin
				rem_q  <= rem_n;
				quo_q  <= quo_n[15:0];
				step_q <= step_q - 1'b1;
				if (step_q == tips_pkg::DSTEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					key_q  <= quo_n[16] ? tips_pkg::KEY_W'(65535) :
						tips_pkg::KEY_W'(quo_n[15:0]);
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.run  = run_q;
	assign res.key  = key_q;

endmodule

// File: rtl/threshold_interval_pixel_sort.sv
// Top level of the threshold interval pixel sort.
// Usage:
//  in channel (in_valid/in_ready/in_data): each word either loads one pixel or
//  fetches one result pixel. Loads fill a row of MAX_WIDTH cells, one pixel per
//  cycle while in_ready is high; the pixel flagged end_of_line closes the line.
//  Extra pixels are dropped. After closing, the key unit visits every cell (with
//  a bit-serial division for hue/saturation), the cells run MAX_WIDTH odd-even
//  compare-swap phases, then MAX_WIDTH minus line length shifts align the line.
//  The key and sort passes span all MAX_WIDTH cells; in_ready is low meanwhile.
//  out channel (out_valid/out_ready/out_data): one word per fetch, in the cycle
//  after the fetch is taken; fetches run at one per cycle unless out_ready stalls.
//  A fetch with no sorted line pending returns zero channels with nothing_ready set. Loads while a sorted
//  line waits are dropped. A stalled out_ready holds the word and in_ready.
//  cfg port (cfg_we/cfg_index/cfg_data): values are latched when a line closes.
//  Reset empties the row and returns to loading; no clearing pass is needed.
module threshold_interval_pixel_sort (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tips_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tips_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	`include "threshold_interval_pixel_sort_macros.svh"

	localparam int N = tips_pkg::MAX_WIDTH;
	localparam int CW = tips_pkg::CNT_W;
	localparam tips_pkg::out_word_t NONE_WORD = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};

	typedef enum logic [2:0] {
		ST_IDLE, ST_KEY_START, ST_KEY_WAIT, ST_SORT, ST_ALIGN, ST_READY
	} state_t;

	state_t              state_q;
	logic [2:0]          mode_q, line_mode_q;
	logic [7:0]          thresh_q, line_thresh_q;
	logic [CW-1:0]       loaded_count_q, fetch_pos_q, step_q;
	logic                out_valid_q;
	tips_pkg::out_word_t out_q;

	tips_pkg::cell_t     cells [N];
	tips_pkg::cell_t     src;
	tips_pkg::cell_ctl_t ctl;
	tips_pkg::key_res_t  key_res;
	logic                acc, is_fetch, last_step, align_last, fetch_last;

	assign in_ready = ((state_q == ST_IDLE) || (state_q == ST_READY)) &&
		(!out_valid_q || out_ready);
	assign acc = in_valid && in_ready;
	assign is_fetch = (in_data.command == tips_pkg::CMD_FETCH);
	assign last_step = (step_q == CW'(N - 1));
	assign align_last = (({1'b0, step_q} + {1'b0, loaded_count_q} + 1'b1) == (CW + 1)'(N));
	assign fetch_last = ((fetch_pos_q + 1'b1) == loaded_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tips_pkg::KEY_LUMA;
			thresh_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tips_pkg::CFG_SORT_KEY_MODE:  mode_q <= cfg_data[2:0];
				tips_pkg::CFG_LUMA_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl = '0;
		src = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !is_fetch && (loaded_count_q < CW'(N))) begin
					ctl.shift = 1'b1;
					src.pixel = {in_data.alpha_in, in_data.blue_in, in_data.green_in,
						in_data.red_in};
					src.valid = 1'b1;
				end
			end
			ST_KEY_WAIT: begin
				if (key_res.done) begin
					ctl.shift = 1'b1;
					src.pixel = cells[N-1].pixel;
					src.key   = key_res.key;
					src.run   = key_res.run;
					src.valid = cells[N-1].valid;
				end
			end
			ST_SORT: begin
				ctl.cmp    = 1'b1;
				ctl.parity = step_q[0];
			end
			ST_ALIGN: ctl.shift = 1'b1;
			ST_READY: ctl.shift = acc && is_fetch;
			default: ;
		endcase
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		tips_pkg::cell_t below_c, above_c;
		if (i == 0) begin : g_lo
			assign below_c = src;
		end else begin : g_lo
			assign below_c = cells[i-1];
		end
		if (i == N - 1) begin : g_hi
			assign above_c = '0;
		end else begin : g_hi
			assign above_c = cells[i+1];
		end
		tips_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.pos_odd (1'(i % 2)),
			.below   (below_c),
			.above   (above_c),
			.cur     (cells[i])
		);
	end

	tips_key u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_KEY_START),
		.pixel  (cells[N-1].pixel),
		.valid  (cells[N-1].valid),
		.mode   (line_mode_q),
		.thresh (line_thresh_q),
		.res    (key_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			line_mode_q    <= tips_pkg::KEY_LUMA;
			line_thresh_q  <= '0;
			loaded_count_q <= '0;
			fetch_pos_q    <= '0;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (acc && is_fetch) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && is_fetch) begin
						out_q <= NONE_WORD;
					end else if (acc) begin
						if (loaded_count_q < CW'(N)) begin
							loaded_count_q <= loaded_count_q + 1'b1;
						end
						if (in_data.end_of_line_in) begin
							line_mode_q   <= mode_q;
							line_thresh_q <= thresh_q;
							step_q        <= '0;
							state_q       <= ST_KEY_START;
						end
					end
				end
				ST_KEY_START: state_q <= ST_KEY_WAIT;
				ST_KEY_WAIT: begin
					if (key_res.done) begin
						if (last_step) begin
							step_q  <= '0;
							state_q <= ST_SORT;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_KEY_START;
						end
					end
				end
				ST_SORT: begin
					if (last_step) begin
						step_q  <= '0;
						state_q <= (loaded_count_q == CW'(N)) ? ST_READY : ST_ALIGN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ALIGN: begin
					step_q <= step_q + 1'b1;
					if (align_last) begin
						state_q <= ST_READY;
					end
				end
				ST_READY: begin
					if (acc && is_fetch) begin
						out_q <= '{red_out: cells[N-1].pixel[7:0],
							green_out: cells[N-1].pixel[15:8],
							blue_out: cells[N-1].pixel[23:16],
							alpha_out: cells[N-1].pixel[31:24],
							end_of_line_out: fetch_last,
							nothing_ready: 1'b0};
						if (fetch_last) begin
							loaded_count_q <= '0;
							fetch_pos_q    <= '0;
							state_q        <= ST_IDLE;
						end else begin
							fetch_pos_q <= fetch_pos_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TIPS_ASSERT_IMP(a_ready_has_line, state_q == ST_READY, loaded_count_q != '0, "sorted line is empty")
	`TIPS_ASSERT_IMP(a_fetch_in_range, state_q == ST_READY, fetch_pos_q < loaded_count_q, "fetch beyond line")
	`TIPS_ASSERT_IMP(a_key_done_wait, key_res.done, state_q == ST_KEY_WAIT, "key result outside key pass")
	`TIPS_ASSERT_NEXT(a_start_then_wait, state_q == ST_KEY_START, state_q == ST_KEY_WAIT, "key pass skipped wait")

endmodule

// File: bench/threshold_interval_pixel_sort_test.sv
// Self-checking testbench for the threshold interval pixel sort top level.
`timescale 1ns / 100ps

module threshold_interval_pixel_sort_test;
	import tips_pkg::*;

	localparam int LIMIT = 6000000;

	typedef struct {
		in_word_t  word;
		bit        typed;
		out_word_t want;
	} stim_t;

	localparam out_word_t NONE = '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
		alpha_out: 8'd0, end_of_line_out: 1'b0, nothing_ready: 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	stim_t      word_q[$];
	out_word_t  pixel_q[$];
	int         fails = 0;
	int         cycles = 0;
	int         items = 0;
	bit         quiet = 0;
	bit         hold_req = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	int         hold_left = 0;

	// predictor state
	logic [31:0] row [MAX_WIDTH];
	int unsigned row_len = 0;
	int unsigned fetch_at = 0;
	bit          row_sorted = 0;
	logic [2:0]  key_mode = KEY_LUMA;
	logic [7:0]  thresh = 8'd0;

	always #6 clk = ~clk;

	threshold_interval_pixel_sort DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int unsigned luma(logic [31:0] px);
		return 299 * px[7:0] + 587 * px[15:8] + 114 * px[23:16];
	endfunction

	function automatic bit in_band(logic [31:0] px);
		int unsigned y;
		y = luma(px);
		return y > 1000 * thresh && y < 255000 - 500 * thresh;
	endfunction

	function automatic int unsigned sort_key(logic [31:0] px);
		int unsigned r, g, b, mx, mn, d, n, s;
		r = px[7:0];
		g = px[15:8];
		b = px[23:16];
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		case (key_mode)
			KEY_HUE: begin
				if (d == 0) return 0;
				if (mx == r) n = (g >= b) ? g - b : 6 * d - (b - g);
				else if (mx == g) n = 2 * d + b - r;
				else n = 4 * d + r - g;
				return (n << 16) / (6 * d);
			end
			KEY_SAT: begin
				if (mx == 0) return 0;
				s = (d << 16) / mx;
				return s > 65535 ? 65535 : s;
			end
			KEY_RED:   return r;
			KEY_GREEN: return g;
			KEY_BLUE:  return b;
			default:   return luma(px);
		endcase
	endfunction

	function automatic void sort_row();
		int unsigned keys [MAX_WIDTH];
		int unsigned i, j, k, m, kv;
		logic [31:0] pv;
		for (i = 0; i < row_len; i++) keys[i] = sort_key(row[i]);
		i = 0;
		while (i < row_len) begin
			if (!in_band(row[i])) begin
				i++;
				continue;
			end
			j = i;
			while (j < row_len && in_band(row[j])) j++;
			for (k = i + 1; k < j; k++) begin
				kv = keys[k];
				pv = row[k];
				m = k;
				while (m > i && keys[m - 1] > kv) begin
					keys[m] = keys[m - 1];
					row[m] = row[m - 1];
					m--;
				end
				keys[m] = kv;
				row[m] = pv;
			end
			i = j;
		end
	endfunction

	function automatic bit predict(in_word_t w, output out_word_t r);
		logic [31:0] px;
		r = NONE;
		if (w.command == CMD_LOAD) begin
			if (row_sorted) return 0;
			if (row_len < MAX_WIDTH) begin
				row[row_len] = {w.alpha_in, w.blue_in, w.green_in, w.red_in};
				row_len++;
			end
			if (w.end_of_line_in) begin
				sort_row();
				fetch_at = 0;
				row_sorted = 1;
			end
			return 0;
		end
		if (!row_sorted || fetch_at >= row_len) return 1;
		px = row[fetch_at];
		r = '{red_out: px[7:0], green_out: px[15:8], blue_out: px[23:16],
			alpha_out: px[31:24], end_of_line_out: 1'b0, nothing_ready: 1'b0};
		if (fetch_at + 1 >= row_len) begin
			r.end_of_line_out = 1'b1;
			row_sorted = 0;
			row_len = 0;
			fetch_at = 0;
		end else begin
			fetch_at++;
		end
		return 1;
	endfunction

	function automatic in_word_t mk(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a, logic eol);
		return '{command: cmd, red_in: r, green_in: g, blue_in: b, alpha_in: a,
			end_of_line_in: eol};
	endfunction

	function automatic in_word_t mk_rand(logic cmd);
		return mk(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom));
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	// sender: advance the word queue, predict on accept
	always @(posedge clk or negedge arst_n) begin
		out_word_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (predict(word_q[0].word, res))
					pixel_q = {pixel_q, word_q[0].typed ? word_q[0].want : res};
				void'(word_q.pop_front());
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (word_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 10);
				in_valid <= 1'b0;
			end else if (word_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= word_q[0].word;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each word, stall at random
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time,
						out_data);
					fails++;
				end else begin
					want = pixel_q.pop_front();
					check_field("red_out", want.red_out, out_data.red_out);
					check_field("green_out", want.green_out, out_data.green_out);
					check_field("blue_out", want.blue_out, out_data.blue_out);
					check_field("alpha_out", want.alpha_out, out_data.alpha_out);
					check_field("end_of_line_out", want.end_of_line_out,
						out_data.end_of_line_out);
					check_field("nothing_ready", want.nothing_ready, out_data.nothing_ready);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req && out_valid) begin
				hold_req = 0;
				hold_left = 300;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push(in_word_t w);
		word_q = {word_q, stim_t'{word: w, typed: 1'b0, want: NONE}};
		items++;
	endtask

	task automatic wait_idle();
		wait (word_q.size() == 0 && !in_valid && pixel_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_SORT_KEY_MODE) key_mode = val[2:0];
		else thresh = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_pixel();
		logic [7:0] p;
		if ($urandom_range(0, 3) == 0) begin
			p = 8'($urandom_range(0, 3) * 85);
			return {8'($urandom), p, 8'($urandom_range(0, 1) * 200), p};
		end
		return $urandom;
	endfunction

	task automatic send_line(int n);
		logic [31:0] px;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) push(mk_rand(CMD_FETCH));
			px = pick_pixel();
			push(mk(CMD_LOAD, px[7:0], px[15:8], px[23:16], px[31:24], i == n - 1));
		end
		if ($urandom_range(0, 3) == 0) push(mk_rand(CMD_LOAD));
		for (int i = 0; i < (n < MAX_WIDTH ? n : MAX_WIDTH); i++)
			push(mk_rand(CMD_FETCH));
		if ($urandom_range(0, 2) == 0) push(mk_rand(CMD_FETCH));
	endtask

	initial begin
		stim_t plan [19];
		logic [7:0] thr;
		int phase;
		plan = '{
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1, NONE},
			'{mk(CMD_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1), 1, NONE},
			'{mk(CMD_LOAD, 8'd255, 8'd0, 8'd0, 8'd17, 1'b0), 0, NONE},
			'{mk(CMD_LOAD, 8'd0, 8'd255, 8'd0, 8'd34, 1'b0), 0, NONE},
			'{mk(CMD_LOAD, 8'd0, 8'd0, 8'd255, 8'd51, 1'b0), 0, NONE},
			'{mk(CMD_LOAD, 8'd128, 8'd128, 8'd128, 8'h5a, 1'b1), 0, NONE},
			'{mk(CMD_LOAD, 8'd1, 8'd2, 8'd3, 8'd4, 1'b1), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1, NONE},
			'{mk(CMD_LOAD, 8'd10, 8'd20, 8'd30, 8'd40, 1'b1), 0, NONE},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1,
				'{8'd10, 8'd20, 8'd30, 8'd40, 1'b1, 1'b0}},
			'{mk(CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 1, NONE}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) word_q = {word_q, plan[i]};

		phase = 0;
		items = 0;
		while (items < 1900) begin
			wait_idle();
			if (phase < 8 || $urandom_range(0, 2) == 0) begin
				write_reg(CFG_SORT_KEY_MODE, phase < 8 ? 8'(phase) : 8'($urandom_range(0, 7)));
				case ($urandom_range(0, 4))
					0: thr = 8'd0;
					1: thr = 8'd255;
					2: thr = 8'($urandom);
					default: thr = 8'($urandom_range(0, 80));
				endcase
				write_reg(CFG_LUMA_THRESHOLD, thr);
			end
			if (phase == 3) hold_req = 1;
			if (phase == 8) send_line(MAX_WIDTH + 2);
			repeat ($urandom_range(1, 2)) send_line($urandom_range(1, 16));
			phase++;
		end

		wait_idle();
		quiet = 1;
		send_line(12);
		send_line(5);
		wait_idle();
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
